// ----- rtl/core/teq_pkg.sv -----
// Shared types and codes for the timer event queue.
package teq_pkg;

	localparam logic [1:0] OP_ADD_TICKS = 2'd0;
	localparam logic [1:0] OP_ADD_SECS  = 2'd1;

	localparam logic [2:0] ST_ADDED     = 3'd0;
	localparam logic [2:0] ST_REJ_EXP   = 3'd1;
	localparam logic [2:0] ST_REJ_FULL  = 3'd2;
	localparam logic [2:0] ST_FIRED     = 3'd3;
	localparam logic [2:0] ST_NONE_DUE  = 3'd4;

	localparam logic [31:0] TPS_RESET = 32'd62500000;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [63:0] now_time;
		logic [31:0] duration;
		logic [15:0] event_tag;
		logic        repeat_flag;
	} in_word_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [15:0] fired_tag;
		logic [63:0] next_deadline;
		logic        queue_empty;
		logic [4:0]  pending_count;
		logic        last_result;
	} out_word_t;

	// classified command handed from front to back
	typedef struct packed {
		logic        is_svc;
		logic        expired;
		logic [63:0] now_time;
		logic [63:0] deadline;
		logic [63:0] delay;
		logic [31:0] tag;
		logic        rep;
	} cmd_word_t;

endpackage

// ----- rtl/core/teq_front.sv -----
// Front end: accepts words, scales seconds, forms deadlines, classifies.
module teq_front #(
	parameter int TAG_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_stall,
	input  teq_pkg::in_word_t  cmd_word,
	input  logic [31:0]        tps,
	input  logic               q_full,
	output logic               q_push,
	output teq_pkg::cmd_word_t q_word
);

	logic              s1_vld_q, s2_vld_q;
	teq_pkg::in_word_t item_s1, item_s2;
	logic [63:0]       delay_s2;
	logic              s1_adv, s2_adv;
	logic [63:0]       dl;
	logic [63:0]       prod;

	assign s2_adv    = s2_vld_q && !q_full;
	assign s1_adv    = s1_vld_q && (!s2_vld_q || s2_adv);
	assign cmd_stall = s1_vld_q && !s1_adv;

	// 32x32 product, registered before the deadline add
	assign prod = 64'(item_s1.duration) * 64'(tps);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_vld_q <= 1'b0;
			s2_vld_q <= 1'b0;
		end else begin
			if (cmd_valid && !cmd_stall) s1_vld_q <= 1'b1;
			else if (s1_adv)             s1_vld_q <= 1'b0;
			if (s1_adv)      s2_vld_q <= 1'b1;
			else if (s2_adv) s2_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && !cmd_stall) item_s1 <= cmd_word;
		if (s1_adv) begin
			item_s2  <= item_s1;
			delay_s2 <= (item_s1.opcode == teq_pkg::OP_ADD_SECS) ? prod
			                                                     : 64'(item_s1.duration);
		end
	end

	assign dl = item_s2.now_time + delay_s2;

	always_comb begin
		q_push          = s2_adv;
		q_word.is_svc   = (item_s2.opcode != teq_pkg::OP_ADD_TICKS) &&
		                  (item_s2.opcode != teq_pkg::OP_ADD_SECS);
		q_word.expired  = (dl <= item_s2.now_time);
		q_word.now_time = item_s2.now_time;
		q_word.deadline = dl;
		q_word.delay    = delay_s2;
		q_word.tag      = 32'(TAG_BITS'(item_s2.event_tag));
		q_word.rep      = item_s2.repeat_flag;
	end

endmodule

// ----- rtl/core/teq_cmd_fifo.sv -----
// Two-entry command queue between front and back.
module teq_cmd_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  teq_pkg::cmd_word_t push_word,
	input  logic               pop,
	output teq_pkg::cmd_word_t pop_word,
	output logic               full,
	output logic               avail
);

	teq_pkg::cmd_word_t ent_q [2];
	logic               wr_ptr_q, rd_ptr_q;
	logic [1:0]         cnt_q;

	assign full     = (cnt_q == 2'd2);
	assign avail    = (cnt_q != 2'd0);
	assign pop_word = ent_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop)  rd_ptr_q <= !rd_ptr_q;
			if (push && !pop)      cnt_q <= cnt_q + 2'd1;
			else if (pop && !push) cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) ent_q[wr_ptr_q] <= push_word;
	end

endmodule

// ----- rtl/core/teq_back.sv -----
// Back end: sorted shift-register store, service sequencer, result register.
module teq_back #(
	parameter int DEPTH    = 16,
	parameter int TAG_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_avail,
	input  teq_pkg::cmd_word_t q_word,
	output logic               q_pop,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output teq_pkg::out_word_t rsp_word
);

	localparam int CNT_W = $clog2(DEPTH + 1);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_INS  = 3'd1;
	localparam logic [2:0] S_SVC  = 3'd2;
	localparam logic [2:0] S_RINS = 3'd3;
	localparam logic [2:0] S_EMIT = 3'd4;

	logic [2:0]          state_q;
	teq_pkg::cmd_word_t  cmd_q;
	logic [CNT_W-1:0]    cnt_q, n_q;
	logic [2:0]          status_q;
	logic [TAG_BITS-1:0] ftag_q;
	logic [63:0]         rdl_q, rper_q;

	logic [63:0]         dl_q   [DEPTH];
	logic [TAG_BITS-1:0] tag_q  [DEPTH];
	logic [63:0]         per_q  [DEPTH];
	logic                mark_q [DEPTH];

	logic                out_vld_q;
	teq_pkg::out_word_t  out_q;

	logic                ins_en, pop_en, due, out_free, last;
	logic [63:0]         ins_dl, ins_per, rsum;
	logic [TAG_BITS-1:0] ins_tag;
	logic                ins_mark;
	logic [DEPTH-1:0]    gt;

	assign out_free = !out_vld_q || !rsp_stall;
	assign due      = (cnt_q != '0) && (dl_q[0] <= cmd_q.now_time) &&
	                  (n_q < CNT_W'(DEPTH));
	assign rsum     = cmd_q.now_time + per_q[0];
	assign last     = (status_q != teq_pkg::ST_FIRED) || !due;

	assign q_pop  = (state_q == S_IDLE) && q_avail;
	assign ins_en = (state_q == S_INS) || (state_q == S_RINS);
	assign pop_en = (state_q == S_SVC) && due;

	always_comb begin
		if (state_q == S_RINS) begin
			ins_dl   = rdl_q;
			ins_tag  = ftag_q;
			ins_per  = rper_q;
			ins_mark = 1'b1;
		end else begin
			ins_dl   = cmd_q.deadline;
			ins_tag  = TAG_BITS'(cmd_q.tag);
			ins_per  = cmd_q.delay;
			ins_mark = cmd_q.rep;
		end
	end

	// entries after the new deadline move up one place
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			gt[i] = (CNT_W'(i) < cnt_q) && (dl_q[i] > ins_dl);
		end
	end

	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		logic take_prev, take_new;
		if (g == 0) begin : g_first
			assign take_prev = 1'b0;
		end else begin : g_rest
			assign take_prev = gt[g-1];
		end
		assign take_new = !take_prev && (gt[g] || (CNT_W'(g) == cnt_q));

		always_ff @(posedge clk) begin
			if (ins_en) begin
				if (take_prev) begin
					dl_q[g]  <= dl_q[(g == 0) ? 0 : g-1];
					tag_q[g] <= tag_q[(g == 0) ? 0 : g-1];
					per_q[g] <= per_q[(g == 0) ? 0 : g-1];
				end else if (take_new) begin
					dl_q[g]  <= ins_dl;
					tag_q[g] <= ins_tag;
					per_q[g] <= ins_per;
				end
			end else if (pop_en && g < DEPTH-1) begin
				dl_q[g]  <= dl_q[(g < DEPTH-1) ? g+1 : g];
				tag_q[g] <= tag_q[(g < DEPTH-1) ? g+1 : g];
				per_q[g] <= per_q[(g < DEPTH-1) ? g+1 : g];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				mark_q[g] <= 1'b0;
			end else if (ins_en) begin
				if (take_prev)     mark_q[g] <= mark_q[(g == 0) ? 0 : g-1];
				else if (take_new) mark_q[g] <= ins_mark;
			end else if (pop_en) begin
				mark_q[g] <= (g < DEPTH-1) ? mark_q[(g < DEPTH-1) ? g+1 : g] : 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if ((state_q == S_EMIT) && out_free) out_vld_q <= 1'b1;
			else if (!rsp_stall)                 out_vld_q <= 1'b0;
			if (ins_en)      cnt_q <= cnt_q + CNT_W'(1);
			else if (pop_en) cnt_q <= cnt_q - CNT_W'(1);
			unique case (state_q)
				S_IDLE: begin
					if (q_avail) begin
						if (q_word.is_svc) state_q <= S_SVC;
						else if (q_word.expired || cnt_q >= CNT_W'(DEPTH)) state_q <= S_EMIT;
						else state_q <= S_INS;
					end
				end
				S_INS:  state_q <= S_EMIT;
				S_SVC: begin
					if (due && mark_q[0] && (rsum > cmd_q.now_time)) state_q <= S_RINS;
					else state_q <= S_EMIT;
				end
				S_RINS: state_q <= S_EMIT;
				S_EMIT: begin
					if (out_free) begin
						state_q <= last ? S_IDLE : S_SVC;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				cmd_q  <= q_word;
				n_q    <= '0;
				ftag_q <= '0;
				if (q_word.expired)                 status_q <= teq_pkg::ST_REJ_EXP;
				else if (cnt_q >= CNT_W'(DEPTH))    status_q <= teq_pkg::ST_REJ_FULL;
				else                                status_q <= teq_pkg::ST_ADDED;
			end
			S_SVC: begin
				if (due) begin
					status_q <= teq_pkg::ST_FIRED;
					ftag_q   <= tag_q[0];
					rdl_q    <= rsum;
					rper_q   <= per_q[0];
					n_q      <= n_q + CNT_W'(1);
				end else begin
					status_q <= teq_pkg::ST_NONE_DUE;
					ftag_q   <= '0;
				end
			end
			S_EMIT: begin
				if (out_free) begin
					out_q.status        <= status_q;
					out_q.fired_tag     <= 16'(32'(ftag_q));
					out_q.next_deadline <= (cnt_q != '0) ? dl_q[0] : 64'd0;
					out_q.queue_empty   <= (cnt_q == '0);
					out_q.pending_count <= 5'(32'(cnt_q));
					out_q.last_result   <= last;
				end
			end
			default: begin
			end
		endcase
	end

	assign rsp_valid = out_vld_q;
	assign rsp_word  = out_q;

endmodule

// ----- rtl/core/timer_event_queue_unit.sv -----
// Top level of the timer event queue: front end, command queue, sorted store.
// Pending timer events are kept in deadline order in a shift-register store
// of DEPTH entries. A two-stage front end registers each command word, scales
// a seconds duration by ticks_per_second in one 32x32 multiply, then adds now
// and flags expired deadlines; words then wait in a two-entry queue for the
// back end. The back end runs one command at a time: an add passes through
// fetch, parallel compare-and-shift insert and result; a rejected add goes
// from fetch to result. A service is fetched, then each fired event passes
// through check and pop, then result; a periodic event that is re-armed has
// a re-insert step between pop and result; when nothing is due it is check,
// then result. Each result sits in an output register, so the back end only
// waits when that register is still held by a stalled consumer. The store
// needs no clearing pass: only entries below the pending count are ever read.
module timer_event_queue_unit #(
	parameter int DEPTH    = 16,
	parameter int TAG_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_stall,
	input  teq_pkg::in_word_t  cmd_word,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output teq_pkg::out_word_t rsp_word,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [31:0]        cfg_data
);

	logic [31:0]        tps_q;
	logic               q_push, q_pop, q_full, q_avail;
	teq_pkg::cmd_word_t q_in, q_out;

	// ticks_per_second; the user must write it only while idle (not enforced here)
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tps_q <= teq_pkg::TPS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			tps_q <= cfg_data;
		end
	end

	teq_front #(.TAG_BITS(TAG_BITS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd_word  (cmd_word),
		.tps       (tps_q),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_word    (q_in)
	);

	teq_cmd_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_word (q_in),
		.pop       (q_pop),
		.pop_word  (q_out),
		.full      (q_full),
		.avail     (q_avail)
	);

	teq_back #(.DEPTH(DEPTH), .TAG_BITS(TAG_BITS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_avail   (q_avail),
		.q_word    (q_out),
		.q_pop     (q_pop),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_word  (rsp_word)
	);

endmodule

// ----- rtl/core/teq_checker.sv -----
// Port-level checks for the timer event queue, bound to the top level.
module teq_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               rsp_valid,
	input logic               rsp_stall,
	input teq_pkg::out_word_t rsp_word
);

	// a held result word stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
		else $error("result word changed while stalled");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_word.queue_empty |->
			rsp_word.pending_count == 5'd0 && rsp_word.next_deadline == 64'd0)
		else $error("empty queue reports entries");

	a_tag: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_word.status != teq_pkg::ST_FIRED |-> rsp_word.fired_tag == 16'd0)
		else $error("tag on a non-fire result");

	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_word.status == teq_pkg::ST_ADDED ||
		              rsp_word.status == teq_pkg::ST_REJ_EXP ||
		              rsp_word.status == teq_pkg::ST_REJ_FULL ||
		              rsp_word.status == teq_pkg::ST_NONE_DUE) |-> rsp_word.last_result)
		else $error("single-result command not marked last");

	a_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_word.queue_empty && rsp_word.status == teq_pkg::ST_ADDED |->
			rsp_word.pending_count != 5'd0 || rsp_word.next_deadline != 64'd0)
		else $error("added event not visible");

endmodule

bind timer_event_queue_unit teq_checker u_teq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp_word  (rsp_word)
);
